[rtl/core/tdpc_pkg.sv]
package tdpc_pkg;

   // Width of the tested integer.
   localparam int VALUE_BITS = 31;
   // Width of the saturating prime count.
   localparam int TALLY_BITS = 32;
   // Trial divisor: covers the square root of the largest value with margin.
   localparam int DIV_BITS   = VALUE_BITS / 2 + 2;
   // Running square of the divisor: one step past the largest value fits.
   localparam int SQ_BITS    = VALUE_BITS + 3;
   // Bit index of the serial remainder.
   localparam int CNT_BITS   = $clog2(VALUE_BITS);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [TALLY_BITS-1:0] tally_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the item, set divisor to three
      logic start_div;  // clear remainder, point at the top value bit
      logic div_step;   // one restoring remainder step
      logic advance;    // next odd divisor, update its square
      logic finish;     // write the result register and the tally
      logic prime;      // verdict that goes with finish
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic below_two;
      logic below_four;
      logic even;
      logic square_above;  // divisor squared exceeds the value
      logic div_last;      // last remainder step is under way
      logic rem_zero;
      logic out_free;      // result register can take a new item
   } dp_status_type;

endpackage

[rtl/core/tdpc_if.sv]
interface tdpc_req_if;
   logic                 valid;
   logic                 ready;
   tdpc_pkg::value_type  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface tdpc_rsp_if;
   logic                 valid;
   logic                 ready;
   tdpc_pkg::value_type  value_echo;
   logic                 is_prime;
   tdpc_pkg::tally_type  primes_so_far;

   modport source (output valid, output value_echo, output is_prime,
                   output primes_so_far, input ready);
   modport sink   (input valid, input value_echo, input is_prime,
                   input primes_so_far, output ready);
endinterface

[rtl/core/trial_division_prime_counter_core.sv]
// Trial-division primality tester with a saturating prime count.
//
// req_chan carries one unsigned value per item; rsp_chan returns one item per
// request: the value echoed, an is_prime flag and the number of primes seen
// since reset, this item included, saturating at all ones. Zero and one are
// not prime. Both channels use valid/ready; an item moves when both are high.
//
// Values below four and even values are judged in the check step, with no
// trial division. An odd value of five or more tries the odd trial divisors
// from three upward, each with a check step, a 31-step bit-serial remainder
// and a judge step. It is not prime when a divisor divides the value, and
// prime once the next divisor's square exceeds the value. One item is in the
// tester at a time; req ready is high only while idle, so the next item is
// taken in the cycle after the result register loads.
//
// The result sits in an output register, so the tester takes the next item
// while an earlier result waits. A stalled receiver holds rsp valid and the
// payload; a finished verdict then waits in the controller until the output
// register frees. Reset (synchronous, active high) clears the prime count,
// drops rsp valid and returns the controller to idle.
module trial_division_prime_counter_core (
   input  logic        clock,
   input  logic        reset,
   tdpc_req_if.sink    req_chan,
   tdpc_rsp_if.source  rsp_chan
);

   tdpc_pkg::dp_cmd_type    cmd;
   tdpc_pkg::dp_status_type status;

   // Sequencer: walks check, divide and judge steps per candidate divisor.
   tdpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: value, divisor, running square, serial remainder, tally and
   // the result register.
   tdpc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_value         (req_chan.value),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_value_echo    (rsp_chan.value_echo),
      .rsp_is_prime      (rsp_chan.is_prime),
      .rsp_primes_so_far (rsp_chan.primes_so_far)
   );

endmodule

[rtl/core/tdpc_dp.sv]
module tdpc_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  tdpc_pkg::dp_cmd_type      cmd,
   output tdpc_pkg::dp_status_type   status,
   input  tdpc_pkg::value_type       req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tdpc_pkg::value_type       rsp_value_echo,
   output logic                      rsp_is_prime,
   output tdpc_pkg::tally_type       rsp_primes_so_far
);

   tdpc_pkg::value_type                 value_ff, value_in;
   logic [tdpc_pkg::DIV_BITS-1:0]       div_ff, div_in;
   logic [tdpc_pkg::SQ_BITS-1:0]        sq_ff, sq_in;
   logic [tdpc_pkg::DIV_BITS-1:0]       rem_ff, rem_in;
   logic [tdpc_pkg::CNT_BITS-1:0]       cnt_ff, cnt_in;
   tdpc_pkg::tally_type                 tally_ff, tally_in;
   logic                                out_valid_ff, out_valid_in;
   tdpc_pkg::value_type                 out_value_ff, out_value_in;
   logic                                out_prime_ff, out_prime_in;
   tdpc_pkg::tally_type                 out_tally_ff, out_tally_in;

   logic [tdpc_pkg::DIV_BITS:0]         rem_shift;
   logic [tdpc_pkg::DIV_BITS:0]         rem_sub;
   logic [tdpc_pkg::DIV_BITS-1:0]       rem_step;

   // Restoring remainder: bring down one value bit, subtract if it fits.
   assign rem_shift = {rem_ff, value_ff[cnt_ff]};
   assign rem_sub   = rem_shift - {1'b0, div_ff};
   assign rem_step  = (rem_shift >= {1'b0, div_ff}) ? rem_sub[tdpc_pkg::DIV_BITS-1:0]
                                                    : rem_shift[tdpc_pkg::DIV_BITS-1:0];

   always_comb begin
      value_in     = value_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      tally_in     = tally_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_prime_in = out_prime_ff;
      out_tally_in = out_tally_ff;

      if (cmd.load) begin
         value_in = req_value;
         div_in   = tdpc_pkg::DIV_BITS'(3);
         sq_in    = tdpc_pkg::SQ_BITS'(9);
      end
      if (cmd.start_div) begin
         rem_in = '0;
         cnt_in = tdpc_pkg::CNT_BITS'(tdpc_pkg::VALUE_BITS - 1);
      end
      if (cmd.div_step) begin
         rem_in = rem_step;
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.advance) begin
         // (d + 2)^2 = d^2 + 4d + 4
         div_in = div_ff + tdpc_pkg::DIV_BITS'(2);
         sq_in  = sq_ff + tdpc_pkg::SQ_BITS'({div_ff, 2'b00}) + tdpc_pkg::SQ_BITS'(4);
      end

      if (cmd.prime && cmd.finish && (tally_ff != '1)) begin
         tally_in = tally_ff + 1'b1;
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_value_in = value_ff;
         out_prime_in = cmd.prime;
         out_tally_in = tally_in;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      div_ff       <= div_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      out_value_ff <= out_value_in;
      out_prime_ff <= out_prime_in;
      out_tally_ff <= out_tally_in;
      if (reset) begin
         tally_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         tally_ff     <= tally_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.below_two    = (value_ff[tdpc_pkg::VALUE_BITS-1:1] == '0);
   assign status.below_four   = (value_ff[tdpc_pkg::VALUE_BITS-1:2] == '0);
   assign status.even         = ~value_ff[0];
   assign status.square_above = (sq_ff > tdpc_pkg::SQ_BITS'(value_ff));
   assign status.div_last     = (cnt_ff == '0);
   assign status.rem_zero     = (rem_ff == '0);
   assign status.out_free     = ~out_valid_ff | rsp_ready;

   assign rsp_valid         = out_valid_ff;
   assign rsp_value_echo    = out_value_ff;
   assign rsp_is_prime      = out_prime_ff;
   assign rsp_primes_so_far = out_tally_ff;

endmodule

[rtl/core/tdpc_ctrl.sv]
module tdpc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tdpc_pkg::dp_status_type   status,
   output tdpc_pkg::dp_cmd_type      cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_JUDGE  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      verdict_ff, verdict_in;

   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      cmd        = '0;
      req_ready  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.below_two) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else if (status.below_four) begin
               verdict_in = 1'b1;
               state_in   = ST_FINISH;
            end else if (status.even) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else if (status.square_above) begin
               verdict_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            if (status.rem_zero) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_FINISH: begin
            // Hold the verdict until the result register frees up.
            if (status.out_free) begin
               cmd.finish = 1'b1;
               cmd.prime  = verdict_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/tdpc_chk.sv]
module tdpc_chk (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tdpc_pkg::value_type  rsp_value_echo,
   input  logic                 rsp_is_prime,
   input  tdpc_pkg::tally_type  rsp_primes_so_far
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_echo)
         && $stable(rsp_primes_so_far))
      else $error("stalled result dropped or changed");

   // Drop any result once reset is seen.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Report zero and one as not prime.
   a_small_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_value_echo[tdpc_pkg::VALUE_BITS-1:1] == '0) |-> !rsp_is_prime)
      else $error("zero or one flagged prime");

   // A prime result always counts itself.
   a_prime_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_prime |-> rsp_primes_so_far != '0)
      else $error("prime result with zero count");

endmodule

bind trial_division_prime_counter_core tdpc_chk u_tdpc_chk (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_value_echo    (rsp_chan.value_echo),
   .rsp_is_prime      (rsp_chan.is_prime),
   .rsp_primes_so_far (rsp_chan.primes_so_far)
);
